### design/audio_interpolating_resampler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interpolating resampler
// Implication and next-cycle implication checks, compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef AUDIO_INTERPOLATING_RESAMPLER_MACROS_SVH
`define AUDIO_INTERPOLATING_RESAMPLER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication under reset
`define AIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler check failed (same cycle)");
// next-cycle implication under reset
`define AIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler check failed (next cycle)");
`else
`define AIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/air_pkg.sv
// ----------------------------------------------------------------------------
// Interpolating resampler package
// Widths, limits, payload types and register codes shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package air_pkg;

    // channel and sample fields
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CI_W         = $clog2(MAX_CHANNELS);
    localparam int SAMPLE_W     = 16;

    // buffer bookkeeping
    localparam int MAX_FRAMES   = 65535;
    localparam int SEEN_W       = 16;
    localparam int MAX_RESULTS  = 24;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    // position Q16.16, step Q4.16
    localparam int STEP_W       = 20;
    localparam int STEP_MIN     = 8192;
    localparam int STEP_MAX     = 524288;
    localparam int POS_W        = 32;
    localparam int FRAC_W       = 16;
    localparam int IDX_W        = POS_W - FRAC_W;
    localparam int LIM_W        = IDX_W + 2;

    // datapath: accumulator, coefficients and shared multiplier
    localparam int V_W          = 38;
    localparam int COEF_W       = 20;
    localparam int MA_W         = V_W - FRAC_W;
    localparam int MP_W         = MA_W + FRAC_W + 1;
    localparam int HORNER_STEPS = 3;
    localparam int HS_W         = 2;

    // register port
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam int REG_IDX_LSB  = 2;

    typedef logic        [CH_W-1:0]     t_channel;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_CUBIC  = 1'b1
    } t_mode;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_STEP = 1'b1
    } t_reg_idx;

endpackage

`default_nettype wire

### design/air_if.sv
// ----------------------------------------------------------------------------
// Interpolating resampler stream interfaces
// Input sample channel and output sample channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface air_in_if;
    logic               valid;
    logic               ready;
    air_pkg::t_channel  channel;
    air_pkg::t_sample   sample_in;
    logic               last_in;

    modport source (output valid, output channel, output sample_in, output last_in,
                    input ready);
    modport sink   (input valid, input channel, input sample_in, input last_in,
                    output ready);
endinterface

interface air_out_if;
    logic               valid;
    logic               ready;
    air_pkg::t_channel  channel_out;
    air_pkg::t_sample   sample_out;
    logic               last_out;

    modport source (output valid, output channel_out, output sample_out, output last_out,
                    input ready);
    modport sink   (input valid, input channel_out, input sample_out, input last_out,
                    output ready);
endinterface

`default_nettype wire

### design/audio_interpolating_resampler.sv
// Sequence: after its position check a result passes fetch, three Horner steps of two
//   multiplies each and emit in cubic mode, or fetch, a linear multiply-add and emit.
// Flow: the input is not ready again until every result of a transfer has been emitted;
//   results are computed one at a time on the single shared 22x17 multiplier.
// Reset: synchronous, active low; clears control state and sets mode cubic, step 1.0;
//   clears kept channel samples, the sample window, position and sample count, not the datapath.
// ----------------------------------------------------------------------------
// Audio interpolating resampler
// Linear or Catmull-Rom cubic resampling of per-channel buffers, one shared
// multiplier driven by a small sequencer, APB register port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "audio_interpolating_resampler_macros.svh"

module audio_interpolating_resampler (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    air_in_if.sink                           i_in,
    air_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [air_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [air_pkg::DATA_W-1:0]  pwdata,
    output logic      [air_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_LOAD   = 7'b0000100,
        S_MUL_LO = 7'b0001000,
        S_MUL_HI = 7'b0010000,
        S_LIN    = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    localparam logic [air_pkg::CNT_W-1:0]  CNT_MAX  = air_pkg::CNT_W'(air_pkg::MAX_RESULTS);
    localparam logic [air_pkg::CNT_W-1:0]  CNT_LAST =
        air_pkg::CNT_W'(air_pkg::MAX_RESULTS - 1);
    localparam logic [air_pkg::SEEN_W-1:0] SEEN_MAX = air_pkg::SEEN_W'(air_pkg::MAX_FRAMES);
    localparam logic [air_pkg::STEP_W-1:0] STEP_LO  = air_pkg::STEP_W'(air_pkg::STEP_MIN);
    localparam logic [air_pkg::STEP_W-1:0] STEP_HI  = air_pkg::STEP_W'(air_pkg::STEP_MAX);
    localparam logic [air_pkg::HS_W-1:0]   HS_LAST  =
        air_pkg::HS_W'(air_pkg::HORNER_STEPS - 1);
    localparam logic signed [air_pkg::V_W-1:0] RND_LIN  =
        air_pkg::V_W'(1) <<< (air_pkg::FRAC_W - 1);
    localparam logic signed [air_pkg::V_W-1:0] RND_CUB  =
        air_pkg::V_W'(1) <<< air_pkg::FRAC_W;
    localparam logic signed [air_pkg::V_W-1:0] SAT_HI   =
        air_pkg::V_W'((2 ** (air_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [air_pkg::V_W-1:0] SAT_LO   = -SAT_HI - air_pkg::V_W'(1);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state                               r_state, n_state;
    air_pkg::t_mode                       r_mode;
    logic [air_pkg::STEP_W-1:0]           r_step;
    air_pkg::t_sample                     r_chan_last [air_pkg::MAX_CHANNELS];
    air_pkg::t_sample                     r_win [4];
    logic [air_pkg::POS_W-1:0]            r_pos;
    logic [air_pkg::POS_W-1:0]            r_np;
    logic [air_pkg::SEEN_W-1:0]           r_seen;
    logic [air_pkg::IDX_W-1:0]            r_k;
    logic signed [air_pkg::LIM_W-1:0]     r_limit;
    logic                                 r_last;
    logic                                 r_final;
    air_pkg::t_channel                    r_channel;
    air_pkg::t_sample                     r_kept;
    logic [air_pkg::CNT_W-1:0]            r_count;
    logic [air_pkg::HS_W-1:0]             r_hstep;
    logic signed [air_pkg::V_W-1:0]       r_v;
    logic [air_pkg::FRAC_W-1:0]           r_t;
    logic signed [air_pkg::COEF_W-1:0]    r_b, r_c, r_d, r_diff;
    logic                                 r_out_valid;
    air_pkg::t_channel                    r_out_channel;
    air_pkg::t_sample                     r_out_sample;
    logic                                 r_out_last;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic               w_cfg_wr;
    air_pkg::t_reg_idx  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = air_pkg::t_reg_idx'(paddr[air_pkg::REG_IDX_LSB]);

    // return the addressed register
    always_comb begin
        case (w_cfg_idx)
            air_pkg::REG_MODE: prdata = air_pkg::DATA_W'(r_mode);
            air_pkg::REG_STEP: prdata = air_pkg::DATA_W'(r_step);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input transfer decode
    // ------------------------------------------------------------------
    logic                             w_take;
    logic [air_pkg::SEEN_W-1:0]       w_seen_next;
    logic                             w_last_eff;
    logic [air_pkg::CI_W-1:0]         w_ci;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_take      = i_in.valid & i_in.ready;
    assign w_seen_next = r_seen + 1'b1;
    assign w_last_eff  = i_in.last_in | (w_seen_next >= SEEN_MAX);
    assign w_ci        = i_in.channel[air_pkg::CI_W-1:0];

    // ------------------------------------------------------------------
    // position check: clamp the step, saturate the next position
    // ------------------------------------------------------------------
    logic [air_pkg::STEP_W-1:0]       w_step;
    logic [air_pkg::POS_W:0]          w_pos_sum;
    logic [air_pkg::POS_W-1:0]        w_pos_next;
    logic signed [air_pkg::LIM_W-1:0] w_idx_s, w_nidx_s;
    logic                             w_more, w_final;

    always_comb begin
        if (r_step < STEP_LO) begin
            w_step = STEP_LO;
        end else if (r_step > STEP_HI) begin
            w_step = STEP_HI;
        end else begin
            w_step = r_step;
        end
    end

    assign w_pos_sum  = {1'b0, r_pos} + (air_pkg::POS_W + 1)'(w_step);
    assign w_pos_next = w_pos_sum[air_pkg::POS_W] ? '1 : w_pos_sum[air_pkg::POS_W-1:0];
    assign w_idx_s    = $signed({2'b00, r_pos[air_pkg::POS_W-1:air_pkg::FRAC_W]});
    assign w_nidx_s   = $signed({2'b00, w_pos_next[air_pkg::POS_W-1:air_pkg::FRAC_W]});
    assign w_more     = (r_count < CNT_MAX) && (w_idx_s <= r_limit);
    assign w_final    = r_last && ((r_count == CNT_LAST) || (w_nidx_s > r_limit));

    // ------------------------------------------------------------------
    // tap fetch: window sample when in the newest four, else kept sample
    // ------------------------------------------------------------------
    logic signed [air_pkg::COEF_W-1:0] w_p [4];
    logic signed [air_pkg::COEF_W-1:0] w_ca, w_cb, w_cc, w_cd;

    always_comb begin
        logic signed [air_pkg::LIM_W-1:0] m;
        logic signed [air_pkg::LIM_W:0]   d;
        for (int j = 0; j < 4; j++) begin
            m = w_idx_s + air_pkg::LIM_W'(j) - air_pkg::LIM_W'(1);
            d = $signed({3'b000, r_k}) - $signed({m[air_pkg::LIM_W-1], m});
            if (m[air_pkg::LIM_W-1] || d[air_pkg::LIM_W]
                    || (d[air_pkg::LIM_W-1:2] != '0)) begin
                w_p[j] = air_pkg::COEF_W'(r_kept);
            end else begin
                w_p[j] = air_pkg::COEF_W'(r_win[~d[1:0]]);
            end
        end
    end

    // Catmull-Rom coefficients, doubled
    assign w_ca = (w_p[3] - w_p[0]) + ((w_p[1] - w_p[2]) <<< 1) + (w_p[1] - w_p[2]);
    assign w_cb = ((w_p[0] <<< 1) + (w_p[2] <<< 2)) - ((w_p[1] <<< 2) + w_p[1]) - w_p[3];
    assign w_cc = w_p[2] - w_p[0];
    assign w_cd = w_p[1] <<< 1;

    // ------------------------------------------------------------------
    // shared multiplier: accumulator halves or linear slope times fraction
    // ------------------------------------------------------------------
    logic signed [air_pkg::MA_W-1:0]     w_mul_a;
    logic signed [air_pkg::FRAC_W:0]     w_mul_f;
    logic signed [air_pkg::MP_W-1:0]     w_prod;
    logic signed [air_pkg::COEF_W-1:0]   w_x;

    always_comb begin
        case (r_state)
            S_MUL_LO: w_mul_a = $signed(air_pkg::MA_W'({1'b0, r_v[air_pkg::FRAC_W-1:0]}));
            S_MUL_HI: w_mul_a = r_v[air_pkg::V_W-1:air_pkg::FRAC_W];
            default:  w_mul_a = air_pkg::MA_W'(r_diff);
        endcase
    end

    assign w_mul_f = $signed({1'b0, r_pos[air_pkg::FRAC_W-1:0]});
    assign w_prod  = w_mul_a * w_mul_f;

    // Horner addend for the current step
    always_comb begin
        case (r_hstep)
            2'd0:    w_x = r_b;
            2'd1:    w_x = r_c;
            default: w_x = r_d;
        endcase
    end

    // ------------------------------------------------------------------
    // round and saturate the finished accumulator
    // ------------------------------------------------------------------
    logic signed [air_pkg::V_W-1:0] w_sum, w_rnd;
    air_pkg::t_sample               w_sat;
    logic                           w_emit;

    always_comb begin
        if (r_mode == air_pkg::MODE_CUBIC) begin
            w_sum = r_v + RND_CUB;
            w_rnd = w_sum >>> (air_pkg::FRAC_W + 1);
        end else begin
            w_sum = r_v + RND_LIN;
            w_rnd = w_sum >>> air_pkg::FRAC_W;
        end
        if (w_rnd > SAT_HI) begin
            w_sat = air_pkg::SAMPLE_W'(SAT_HI);
        end else if (w_rnd < SAT_LO) begin
            w_sat = air_pkg::SAMPLE_W'(SAT_LO);
        end else begin
            w_sat = air_pkg::SAMPLE_W'(w_rnd);
        end
    end

    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = w_more ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                n_state = (r_mode == air_pkg::MODE_CUBIC) ? S_MUL_LO : S_LIN;
            end
            S_MUL_LO: begin
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_state = (r_hstep == HS_LAST) ? S_EMIT : S_MUL_LO;
            end
            S_LIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) n_state = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and buffer state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= air_pkg::MODE_CUBIC;
            r_step      <= air_pkg::STEP_W'(65536);
            r_pos       <= '0;
            r_seen      <= '0;
            r_count     <= '0;
            r_hstep     <= '0;
            r_last      <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < air_pkg::MAX_CHANNELS; i++) begin
                r_chan_last[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // register writes
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    air_pkg::REG_MODE: r_mode <= air_pkg::t_mode'(pwdata[0]);
                    air_pkg::REG_STEP: r_step <= pwdata[air_pkg::STEP_W-1:0];
                    default:           r_mode <= r_mode;
                endcase
            end

            // take a sample: shift the window, keep the buffer's final sample
            if (w_take) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_win[3];
                r_win[3] <= i_in.sample_in;
                r_seen   <= w_seen_next;
                r_last   <= w_last_eff;
                r_count  <= '0;
                if (w_last_eff) r_chan_last[w_ci] <= i_in.sample_in;
            end

            // end of item: rewind position after the buffer's last sample
            if ((r_state == S_CHECK) && !w_more && r_last) begin
                r_pos  <= '0;
                r_seen <= '0;
            end

            if ((r_state == S_CHECK) && w_more) begin
                r_final <= w_final;
            end

            if (r_state == S_LOAD) r_hstep <= '0;
            if (r_state == S_MUL_HI) r_hstep <= r_hstep + 1'b1;

            // hand over a result, advance the position
            if (w_emit) begin
                r_pos       <= r_np;
                r_count     <= r_count + 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_channel <= i_in.channel;
            r_kept    <= r_chan_last[w_ci];
            r_k       <= r_seen;
            r_limit   <= w_last_eff ? $signed({2'b00, r_seen})
                                    : $signed({2'b00, r_seen}) - air_pkg::LIM_W'(2);
        end

        if ((r_state == S_CHECK) && w_more) r_np <= w_pos_next;

        // load taps and coefficients
        if (r_state == S_LOAD) begin
            r_b    <= w_cb;
            r_c    <= w_cc;
            r_d    <= w_cd;
            r_diff <= w_p[2] - w_p[1];
            if (r_mode == air_pkg::MODE_CUBIC) begin
                r_v <= air_pkg::V_W'(w_ca) <<< air_pkg::FRAC_W;
            end else begin
                r_v <= air_pkg::V_W'(w_p[1]) <<< air_pkg::FRAC_W;
            end
        end

        // low half of the accumulator times the fraction, keep the floor
        if (r_state == S_MUL_LO) begin
            r_t <= w_prod[2*air_pkg::FRAC_W-1:air_pkg::FRAC_W];
        end

        // high half times the fraction, add low part and next coefficient
        if (r_state == S_MUL_HI) begin
            r_v <= $signed(w_prod[air_pkg::V_W-1:0]) + $signed(air_pkg::V_W'(r_t))
                 + (air_pkg::V_W'(w_x) <<< air_pkg::FRAC_W);
        end

        if (r_state == S_LIN) begin
            r_v <= r_v + $signed(w_prod[air_pkg::V_W-1:0]);
        end

        if (w_emit) begin
            r_out_channel <= r_channel;
            r_out_sample  <= w_sat;
            r_out_last    <= r_final;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.channel_out = r_out_channel;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.last_out    = r_out_last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `AIR_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX)
    `AIR_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, w_take, !i_in.ready)
    `AIR_ASSERT_IMP(a_seen_below_max, i_clk, i_rst_n, r_state == S_IDLE, r_seen < SEEN_MAX)
    `AIR_ASSERT_IMP(a_final_needs_last, i_clk, i_rst_n, w_emit && r_final, r_last)

endmodule

`default_nettype wire
